// ===== rtl/hthd_pkg.sv =====
// ----------------------------------------------------------------------------
// hthd_pkg
// Shared types, sizes and codes of the Huffman tree header decoder.
// ----------------------------------------------------------------------------
package hthd_pkg;

	localparam int STACK_DEPTH = 256;
	localparam int MAX_NODES   = 512;

	localparam int SP_W   = $clog2(STACK_DEPTH);
	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int NODE_W = $clog2(MAX_NODES + 1);
	localparam int IDX_W  = 9;
	localparam int SYM_W  = 8;
	localparam int ST_W   = 3;
	localparam int TDATA_W = 40;
	localparam int TUSER_W = 2;

	localparam logic [SYM_W-1:0] CMD_ONE  = 8'd49;
	localparam logic [SYM_W-1:0] CMD_ZERO = 8'd48;
	localparam logic [SYM_W-1:0] TOP_BIT  = 8'h80;

	localparam logic [3:0] SYM_BITS = 4'd8;

	localparam logic [ST_W-1:0] ST_OK    = 3'd0;
	localparam logic [ST_W-1:0] ST_UNDER = 3'd1;
	localparam logic [ST_W-1:0] ST_OVER  = 3'd2;
	localparam logic [ST_W-1:0] ST_LIMIT = 3'd3;
	localparam logic [ST_W-1:0] ST_EARLY = 3'd4;

	localparam logic FMT_BITS = 1'b0;
	localparam logic FMT_CHAR = 1'b1;

	localparam logic REG_FORMAT = 1'b0;

	typedef struct packed {
		logic [IDX_W-1:0] node_index;
		logic             node_kind;
		logic [SYM_W-1:0] leaf_symbol;
		logic [IDX_W-1:0] left_index;
		logic [IDX_W-1:0] right_index;
		logic             tree_done;
		logic [ST_W-1:0]  status;
	} rec_t;

	typedef struct packed {
		logic go;
		logic emit;
		logic byte_end;
	} step_t;

endpackage

// ===== rtl/hthd_ram.sv =====
// ----------------------------------------------------------------------------
// hthd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module hthd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/hthd_core.sv =====
// ----------------------------------------------------------------------------
// hthd_core
// Header bit engine: decodes one header bit or character per cycle unless the
// output stalls it, on a node index stack in RAM, top entry in a register.
// ----------------------------------------------------------------------------
module hthd_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [hthd_pkg::SYM_W-1:0]  in_data,
	input  logic                        in_end,
	output logic                        in_ready,
	input  logic                        fmt,
	input  logic                        restart,
	input  logic                        can_emit,
	output hthd_pkg::step_t             step,
	output hthd_pkg::rec_t              rec
);

	logic                        busy_q;
	logic [hthd_pkg::SYM_W-1:0]  bits_q;
	logic                        endm_q;
	logic [2:0]                  k_q;

	logic [hthd_pkg::CNT_W-1:0]  count_q, n_count;
	logic [hthd_pkg::NODE_W-1:0] next_q, n_next;
	logic [3:0]                  pend_q, n_pend;
	logic [hthd_pkg::SYM_W-1:0]  shift_q, n_shift;
	logic                        err_q, n_err;
	logic [hthd_pkg::IDX_W-1:0]  top_q, n_top;
	logic [hthd_pkg::IDX_W-1:0]  beneath_q, n_beneath;
	logic                        bsel_q, n_bsel;

	logic                        we, re;
	logic [hthd_pkg::SP_W-1:0]   waddr, raddr;
	logic [hthd_pkg::IDX_W-1:0]  rdata;
	logic [hthd_pkg::IDX_W-1:0]  beneath;
	logic [hthd_pkg::IDX_W-1:0]  idx;

	logic                        bit_in, leaf_op, zero_op, stop, emit, reset_tree;
	logic [hthd_pkg::SYM_W-1:0]  sym;
	logic                        byte_end, go;

	hthd_ram #(
		.WIDTH(hthd_pkg::IDX_W),
		.DEPTH(hthd_pkg::STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (we && go),
		.waddr(waddr),
		.wdata(top_q),
		.re   (re && go),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign beneath = bsel_q ? rdata : beneath_q;
	assign idx     = hthd_pkg::IDX_W'(next_q);
	assign bit_in  = |(bits_q & hthd_pkg::TOP_BIT);
	assign waddr   = hthd_pkg::SP_W'(count_q - hthd_pkg::CNT_W'(1));
	assign raddr   = hthd_pkg::SP_W'(count_q - hthd_pkg::CNT_W'(3));

	always_comb begin
		n_count    = count_q;
		n_next     = next_q;
		n_pend     = pend_q;
		n_shift    = shift_q;
		n_err      = err_q;
		n_top      = top_q;
		n_beneath  = beneath_q;
		n_bsel     = bsel_q;
		leaf_op    = 1'b0;
		zero_op    = 1'b0;
		sym        = '0;
		stop       = 1'b0;
		emit       = 1'b0;
		reset_tree = 1'b0;
		rec        = '0;
		we         = 1'b0;
		re         = 1'b0;

		if (endm_q) begin
			if (err_q) begin
				n_err = 1'b0;
			end else if (count_q != '0 || pend_q != '0) begin
				emit       = 1'b1;
				rec.status = hthd_pkg::ST_EARLY;
			end
			reset_tree = 1'b1;
		end else if (!err_q) begin
			if (fmt == hthd_pkg::FMT_BITS) begin
				if (pend_q != '0) begin
					n_shift = {shift_q[hthd_pkg::SYM_W-2:0], bit_in};
					n_pend  = pend_q - 4'd1;
					if (pend_q == 4'd1) begin
						leaf_op = 1'b1;
						sym     = n_shift;
					end
				end else if (bit_in) begin
					n_pend  = hthd_pkg::SYM_BITS;
					n_shift = '0;
				end else begin
					zero_op = 1'b1;
				end
			end else begin
				if (pend_q != '0) begin
					n_pend  = '0;
					leaf_op = 1'b1;
					sym     = bits_q;
				end else if (bits_q == hthd_pkg::CMD_ONE) begin
					n_pend = 4'd1;
				end else if (bits_q == hthd_pkg::CMD_ZERO) begin
					zero_op = 1'b1;
				end
			end
		end

		if (leaf_op) begin
			emit = 1'b1;
			if (next_q >= hthd_pkg::NODE_W'(hthd_pkg::MAX_NODES)) begin
				rec.status = hthd_pkg::ST_LIMIT;
				n_err      = 1'b1;
				stop       = 1'b1;
			end else if (count_q >= hthd_pkg::CNT_W'(hthd_pkg::STACK_DEPTH)) begin
				rec.status = hthd_pkg::ST_OVER;
				n_err      = 1'b1;
				stop       = 1'b1;
			end else begin
				rec.node_index  = idx;
				rec.leaf_symbol = sym;
				n_next          = next_q + hthd_pkg::NODE_W'(1);
				n_count         = count_q + hthd_pkg::CNT_W'(1);
				n_top           = idx;
				if (count_q != '0) begin
					we        = 1'b1;
					n_beneath = top_q;
					n_bsel    = 1'b0;
				end
			end
		end

		if (zero_op) begin
			emit = 1'b1;
			stop = 1'b1;
			if (count_q == '0) begin
				rec.status = hthd_pkg::ST_UNDER;
				n_err      = 1'b1;
			end else if (count_q == hthd_pkg::CNT_W'(1)) begin
				rec.node_index = top_q;
				rec.node_kind  = (next_q > hthd_pkg::NODE_W'(1));
				rec.tree_done  = 1'b1;
				reset_tree     = 1'b1;
			end else if (next_q >= hthd_pkg::NODE_W'(hthd_pkg::MAX_NODES)) begin
				rec.status = hthd_pkg::ST_LIMIT;
				n_err      = 1'b1;
			end else begin
				stop            = 1'b0;
				rec.node_index  = idx;
				rec.node_kind   = 1'b1;
				rec.left_index  = beneath;
				rec.right_index = top_q;
				n_next          = next_q + hthd_pkg::NODE_W'(1);
				n_count         = count_q - hthd_pkg::CNT_W'(1);
				n_top           = idx;
				re              = 1'b1;
				n_bsel          = 1'b1;
			end
		end

		if (reset_tree) begin
			n_count = '0;
			n_next  = '0;
			n_pend  = '0;
			n_shift = '0;
		end
	end

	assign byte_end = endm_q || err_q || (fmt == hthd_pkg::FMT_CHAR) || stop || (k_q == 3'd7);
	assign go       = busy_q && !(emit && !can_emit);
	assign in_ready = !busy_q || (go && byte_end);

	assign step.go       = go;
	assign step.emit     = go && emit;
	assign step.byte_end = byte_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			k_q     <= '0;
			count_q <= '0;
			next_q  <= '0;
			pend_q  <= '0;
			shift_q <= '0;
			err_q   <= 1'b0;
			bsel_q  <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (go) begin
				if (byte_end) begin
					busy_q <= 1'b0;
				end
				k_q <= k_q + 3'd1;
			end
			if (restart) begin
				count_q <= '0;
				next_q  <= '0;
				pend_q  <= '0;
				shift_q <= '0;
				err_q   <= 1'b0;
			end else if (go) begin
				count_q <= n_count;
				next_q  <= n_next;
				pend_q  <= n_pend;
				shift_q <= n_shift;
				err_q   <= n_err;
				bsel_q  <= n_bsel;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			bits_q <= in_data;
			endm_q <= in_end;
		end else if (go) begin
			bits_q <= {bits_q[hthd_pkg::SYM_W-2:0], 1'b0};
		end
		if (go) begin
			top_q     <= n_top;
			beneath_q <= n_beneath;
		end
	end

endmodule

// ===== rtl/hthd_out.sv =====
// ----------------------------------------------------------------------------
// hthd_out
// Result staging: holds the newest record until it is known whether it is
// the final one of its input byte, then passes it to the output register.
// ----------------------------------------------------------------------------
module hthd_out (
	input  logic            clk,
	input  logic            arst_n,
	input  hthd_pkg::step_t step,
	input  hthd_pkg::rec_t  rec,
	output logic            can_emit,
	output logic            out_valid,
	input  logic            out_ready,
	output hthd_pkg::rec_t  out_rec,
	output logic            out_last
);

	logic           out_valid_q;
	hthd_pkg::rec_t out_rec_q;
	logic           out_last_q;
	logic           pend_valid_q;
	logic           pend_final_q;
	hthd_pkg::rec_t pend_rec_q;
	logic           out_avail;
	logic           move;

	assign out_avail = !out_valid_q || out_ready;
	assign move      = pend_valid_q && out_avail && (pend_final_q || step.emit);
	assign can_emit  = !pend_valid_q || out_avail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
			pend_final_q <= 1'b0;
		end else begin
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (step.emit) begin
				pend_valid_q <= 1'b1;
				pend_final_q <= step.byte_end;
			end else if (move) begin
				pend_valid_q <= 1'b0;
			end else if (step.go && step.byte_end && pend_valid_q) begin
				pend_final_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_rec_q  <= pend_rec_q;
			out_last_q <= pend_final_q;
		end
		if (step.emit) begin
			pend_rec_q <= rec;
		end
	end

	assign out_valid = out_valid_q;
	assign out_rec   = out_rec_q;
	assign out_last  = out_last_q;

endmodule

// ===== rtl/huffman_tree_header_decoder.sv =====
// ----------------------------------------------------------------------------
// huffman_tree_header_decoder
// Rebuilds a Huffman code tree from a post-order header stream and emits one
// record for each node created, with status codes for malformed headers.
// ----------------------------------------------------------------------------
// A request on the input stream is registered when taken and worked on
// afterwards; the next one is taken as its predecessor finishes. In bit-packed
// format a byte is worked on one header bit per cycle, because each bit may
// pop two stack entries and push one through the stack memory and its single
// read port, unless a stalled output holds the engine, which it does only
// when it has a new record to place. A byte that finishes a tree or hits an
// error may end before its last bit. A character-format byte and an end marker
// are each worked on whole. A result request is staged until a later record
// comes or its byte ends. The stack RAM needs no clearing pass after reset.
module huffman_tree_header_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	// s_tdata: data_byte[7:0]
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,
	input  logic                          s_tlast,
	// m_tdata: node_index[8:0], leaf_symbol[16:9], left_index[25:17],
	// right_index[34:26], status[37:35], zero[39:38]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [hthd_pkg::TDATA_W-1:0]  m_tdata,
	// m_tuser: node_kind[0], tree_done[1]
	output logic [hthd_pkg::TUSER_W-1:0]  m_tuser,
	output logic                          m_tlast,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	logic            fmt_q;
	logic            cfg_wr;
	logic            restart;
	logic            can_emit;
	hthd_pkg::step_t step;
	hthd_pkg::rec_t  rec;
	hthd_pkg::rec_t  out_rec;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign restart = cfg_wr && (paddr[2] == hthd_pkg::REG_FORMAT);
	assign prdata  = (paddr[2] == hthd_pkg::REG_FORMAT) ? {31'd0, fmt_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= hthd_pkg::FMT_BITS;
		end else if (restart) begin
			fmt_q <= pwdata[0];
		end
	end

	hthd_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_data (s_tdata),
		.in_end  (s_tlast),
		.in_ready(s_tready),
		.fmt     (fmt_q),
		.restart (restart),
		.can_emit(can_emit),
		.step    (step),
		.rec     (rec)
	);

	hthd_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.rec      (rec),
		.can_emit (can_emit),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_rec  (out_rec),
		.out_last (m_tlast)
	);

	assign m_tdata = {2'b00, out_rec.status, out_rec.right_index, out_rec.left_index,
		out_rec.leaf_symbol, out_rec.node_index};
	assign m_tuser = {out_rec.tree_done, out_rec.node_kind};

endmodule

// ===== rtl/hthd_checker.sv =====
// ----------------------------------------------------------------------------
// hthd_checker
// Port-level checks of the Huffman tree header decoder, bound to the top.
// ----------------------------------------------------------------------------
module hthd_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [hthd_pkg::TDATA_W-1:0] m_tdata,
	input logic [hthd_pkg::TUSER_W-1:0] m_tuser,
	input logic                         pready
);

	a_done_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata[37:35] == hthd_pkg::ST_OK)
		else $error("tree completion record carries an error status");

	a_err_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[37:35] != hthd_pkg::ST_OK
		|-> m_tdata[34:0] == '0 && m_tuser == '0)
		else $error("error record carries node fields");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[37:35] <= hthd_pkg::ST_EARLY)
		else $error("undefined status code");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result request changed");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("configuration port not ready");

endmodule

bind huffman_tree_header_decoder hthd_checker u_hthd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.pready  (pready)
);
